// File: hdl/ladc_pkg.sv
// ----------------------------------------------------------------------------
// ladc_pkg
// Shared constants for the load-cell converter reader.
// ----------------------------------------------------------------------------
package ladc_pkg;

  // default read geometry
  localparam int DATA_BITS_DEF    = 17;
  localparam int TOTAL_PULSES_DEF = 25;

  // calibration word that turns calibration off
  localparam logic [31:0] CAL_DISABLE = 32'hFFFF_FFFF;

  // register reset values
  localparam logic [31:0] CAL_OFFSET_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] CAL_SCALE_RST  = 32'hFFFF_FFFF;
  localparam logic [7:0]  HALF_RST       = 8'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF       = 2'd2;

  // saturation limit of the weight
  localparam logic [31:0] WEIGHT_MAX = 32'h0000_FFFF;

endpackage

// File: hdl/load_cell_adc_reader.sv
// ----------------------------------------------------------------------------
// load_cell_adc_reader
// Tick-driven master for a two-wire load-cell converter with calibration.
// ----------------------------------------------------------------------------
// Each input transaction is one timing tick of the pin interface and produces
// exactly one result transaction, one tick per clock when neither side
// stalls. The tick is processed in the cycle it is taken and its result lands
// in an output register; a one-entry skid register lets a tick be taken while
// a result waits, so in_stall only rises after two results are held. The
// calibration multiply (raw - offset) * scale runs in a two-stage register
// pipeline that follows the shift register continuously; the shift register
// is frozen after the last data bit, before the read completes, so the
// product is ready when the done tick arrives. There is no
// clearing pass after reset. Configuration writes are taken at any time
// (cfg_ready is always high) and must be made while no read is running.
// ----------------------------------------------------------------------------
module load_cell_adc_reader #(
  parameter int DATA_BITS    = ladc_pkg::DATA_BITS_DEF,
  parameter int TOTAL_PULSES = ladc_pkg::TOTAL_PULSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // tick channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_start_req,
  input  logic                           in_power_down,
  input  logic                           in_dout_level,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_sck_level,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [15:0]                    out_weight,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ladc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam logic [4:0] DATA_BITS_C    = 5'(DATA_BITS);
  localparam logic [4:0] TOTAL_PULSES_C = 5'(TOTAL_PULSES);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SETTLE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef struct packed {
    logic        sck;
    logic        busy;
    logic        done;
    logic [15:0] weight;
  } result_t;

  // configuration registers
  logic [31:0] cal_offset_r;
  logic [31:0] cal_scale_r;
  logic [7:0]  half_r;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             tick_r, tick_nxt;
  logic [4:0]             pulse_r, pulse_nxt;
  logic [DATA_BITS-1:0]   raw_r, raw_nxt;
  logic                   clk_out_r, clk_out_nxt;
  logic [15:0]            weight_r, weight_nxt;
  logic                   done_nxt;

  // calibration pipeline
  logic [31:0] diff_r;
  logic [31:0] prod_r;

  // output register and skid
  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  result_t res_new;

  logic in_fire;
  logic out_fire;

  // timer helpers
  logic [7:0]         half_eff;
  logic [7:0]         tick_inc;
  logic               timer_done;
  logic               data_bit;
  logic [DATA_BITS:0] raw_shift;
  logic [4:0]         pulse_inc;

  // calibration result helpers
  logic        cal_en;
  logic [31:0] byp_val;
  logic [31:0] cal_val;
  logic [15:0] weight_cal;

  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  // half period timer, zero treated as one tick
  assign half_eff   = (half_r == 8'd0) ? 8'd1 : half_r;
  assign tick_inc   = tick_r + 8'd1;
  assign timer_done = (tick_inc >= half_eff);

  // first data bit comes inverted
  assign data_bit  = (pulse_r == 5'd0) ? !in_dout_level : in_dout_level;
  assign raw_shift = {raw_r, data_bit};
  assign pulse_inc = pulse_r + 5'd1;

  // final calibration step, product comes from the pipeline
  assign cal_en     = (cal_offset_r != ladc_pkg::CAL_DISABLE) &&
                      (cal_scale_r != ladc_pkg::CAL_DISABLE);
  assign byp_val    = 32'(raw_r) >> 1;
  assign cal_val    = cal_en ? {8'd0, prod_r[31:8]} : byp_val;
  assign weight_cal = (cal_val > ladc_pkg::WEIGHT_MAX) ? 16'hFFFF : cal_val[15:0];

  // next state for one tick
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    pulse_nxt   = pulse_r;
    raw_nxt     = raw_r;
    clk_out_nxt = clk_out_r;
    weight_nxt  = weight_r;
    done_nxt    = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_start_req) begin
          clk_out_nxt = 1'b0;
          phase_nxt   = PH_WAIT;
          tick_nxt    = 8'd0;
          pulse_nxt   = 5'd0;
          raw_nxt     = '0;
        end else if (in_power_down) begin
          clk_out_nxt = 1'b1;
        end
      end
      PH_WAIT: begin
        if (!in_dout_level) begin
          phase_nxt = PH_SETTLE;
          tick_nxt  = 8'd0;
        end
      end
      PH_SETTLE: begin
        tick_nxt = timer_done ? 8'd0 : tick_inc;
        if (timer_done) begin
          phase_nxt   = PH_HIGH;
          clk_out_nxt = 1'b1;
        end
      end
      PH_HIGH: begin
        tick_nxt = timer_done ? 8'd0 : tick_inc;
        if (timer_done) begin
          if (pulse_r < DATA_BITS_C) begin
            raw_nxt = raw_shift[DATA_BITS-1:0];
          end
          phase_nxt   = PH_LOW;
          clk_out_nxt = 1'b0;
        end
      end
      PH_LOW: begin
        tick_nxt = timer_done ? 8'd0 : tick_inc;
        if (timer_done) begin
          if (pulse_inc >= TOTAL_PULSES_C) begin
            weight_nxt = weight_cal;
            done_nxt   = 1'b1;
            phase_nxt  = PH_IDLE;
            pulse_nxt  = 5'd0;
          end else begin
            pulse_nxt   = pulse_inc;
            phase_nxt   = PH_HIGH;
            clk_out_nxt = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // result of the current tick
  always_comb begin
    res_new.sck    = clk_out_nxt;
    res_new.busy   = (phase_nxt != PH_IDLE);
    res_new.done   = done_nxt;
    res_new.weight = weight_nxt;
  end

  // calibration pipeline follows the frozen shift register
  always_ff @(posedge clk) begin
    diff_r <= 32'(raw_r) - cal_offset_r;
    prod_r <= diff_r * cal_scale_r;
  end

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_offset_r <= ladc_pkg::CAL_OFFSET_RST;
      cal_scale_r  <= ladc_pkg::CAL_SCALE_RST;
      half_r       <= ladc_pkg::HALF_RST;
      phase_r      <= PH_IDLE;
      tick_r       <= 8'd0;
      pulse_r      <= 5'd0;
      raw_r        <= '0;
      clk_out_r    <= 1'b1;
      weight_r     <= 16'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      out_data_r   <= '0;
      skid_data_r  <= '0;
    end else begin
      // configuration write
      if (cfg_valid) begin
        unique case (cfg_index)
          ladc_pkg::REG_CAL_OFFSET: cal_offset_r <= cfg_data;
          ladc_pkg::REG_CAL_SCALE:  cal_scale_r  <= cfg_data;
          ladc_pkg::REG_HALF:       half_r       <= cfg_data[7:0];
          default: ;
        endcase
      end

      // sequencer advances on each accepted tick
      if (in_fire) begin
        phase_r   <= phase_nxt;
        tick_r    <= tick_nxt;
        pulse_r   <= pulse_nxt;
        raw_r     <= raw_nxt;
        clk_out_r <= clk_out_nxt;
        weight_r  <= weight_nxt;
      end

      // output register with skid entry
      if (skid_valid_r) begin
        if (out_fire) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_valid_r || out_fire) begin
          out_data_r  <= res_new;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= res_new;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sck_level = out_data_r.sck;
  assign out_busy_res  = out_data_r.busy;
  assign out_done_res  = out_data_r.done;
  assign out_weight    = out_data_r.weight;

endmodule
